// File: rtl/multi_mode_byte_crc_unit_assert.svh
// assertion macros for the multi-mode byte crc unit checker
// depends on nothing; included by the checker file only
`ifndef MULTI_MODE_BYTE_CRC_UNIT_ASSERT_SVH
`define MULTI_MODE_BYTE_CRC_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define MMBC_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mmbc assertion failed");

// next-cycle implication, disabled while reset is asserted
`define MMBC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mmbc assertion failed");

`endif

// File: rtl/mmbc_pkg.sv
// shared types, constants and table functions for the multi-mode byte crc unit
// no dependencies; used by mmbc_crc_next and the top level
`default_nettype none

package mmbc_pkg;

    localparam logic [15:0] CCITT_POLY = 16'h1021;
    localparam logic [31:0] CRC32_POLY = 32'hEDB8_8320;
    localparam logic [15:0] CRC16_INIT = 16'h0000;
    localparam logic [31:0] CRC32_INIT = 32'hFFFF_FFFF;

    // mode register codes
    localparam logic [1:0] MODE_CCITT_AUG    = 2'd0;
    localparam logic [1:0] MODE_CCITT_DIRECT = 2'd1;
    localparam logic [1:0] MODE_CRC32        = 2'd2;

    // one input transaction held in the input register
    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } mmbc_item_t;

    // ccitt table term for one byte, msb first
    function automatic logic [15:0] ccitt_term(input logic [7:0] b);
        logic [15:0] t;
        t = {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (t[15])
                t = {t[14:0], 1'b0} ^ CCITT_POLY;
            else
                t = {t[14:0], 1'b0};
        end
        return t;
    endfunction

    // reflected crc-32 table term for one byte
    function automatic logic [31:0] crc32_term(input logic [7:0] b);
        logic [31:0] c;
        c = {24'h000000, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = {1'b0, c[31:1]} ^ CRC32_POLY;
            else
                c = {1'b0, c[31:1]};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/multi_mode_byte_crc_unit.sv
// Running CRC over a byte stream: augmented CCITT-16, direct CCITT-16 or
// reflected CRC-32, selected by a two-bit mode register.
// Input channel s_*: one byte per transaction in s_tdata, restart flag in
// s_tuser; restart reloads the mode's initial value before the byte.
// Output channel m_*: one transaction per input, m_tdata carries the CRC
// register after that byte (upper 16 bits zero in the 16-bit modes).
// Mode port: crc_mode_wr_en / crc_mode_wr_data, written while idle.
// Path: a byte passes the input register, then the CRC/result register,
// before its result transaction completes. Throughput: one byte per cycle
// while the output is not stalled, limited by the CRC feedback through the
// table logic.
// A new byte is taken while a result waits, as long as the input register
// can move on; when m_tready stays low the result and one more byte are
// held, then s_tready drops.
// Reset clears the valid flags, the mode to 0 and the CRC register to 0.
// depends on mmbc_pkg and mmbc_crc_next
`default_nettype none

module multi_mode_byte_crc_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // mode register write port
    input  wire logic        crc_mode_wr_en,
    input  wire logic [1:0]  crc_mode_wr_data,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] restart
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [31:0] crc_value
);

    logic [1:0]           crc_mode_reg;
    mmbc_pkg::mmbc_item_t in_item_reg;
    logic                 in_valid_reg;
    logic [31:0]          crc_reg;
    logic [31:0]          crc_next;
    logic [31:0]          out_data_reg;
    logic                 out_valid_reg;
    logic                 advance;

    // the held item moves into the crc stage when the result slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_mode_reg <= mmbc_pkg::MODE_CCITT_AUG;
        else if (crc_mode_wr_en)
            crc_mode_reg <= crc_mode_wr_data;
    end

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.data_byte <= s_tdata;
            in_item_reg.restart   <= s_tuser;
        end
    end

    mmbc_crc_next u_crc_next (
        .crc_mode (crc_mode_reg),
        .item     (in_item_reg),
        .crc_cur  (crc_reg),
        .crc_new  (crc_next)
    );

    // crc state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= {16'h0000, mmbc_pkg::CRC16_INIT};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                crc_reg <= crc_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= crc_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// File: rtl/mmbc_crc_next.sv
// next crc value for one byte in each of the three modes
// depends on mmbc_pkg
`default_nettype none

module mmbc_crc_next (
    input  wire logic [1:0]        crc_mode,
    input  wire mmbc_pkg::mmbc_item_t item,
    input  wire logic [31:0]       crc_cur,
    output logic [31:0]            crc_new
);

    logic        is_crc32;
    logic [31:0] crc_start;
    logic [15:0] r16;

    // mode three decodes as crc-32, only bit 1 is looked at
    assign is_crc32 = crc_mode[1];

    // restart reloads the initial value before the byte
    always_comb
    begin
        if (item.restart)
            crc_start = is_crc32 ? mmbc_pkg::CRC32_INIT : {16'h0000, mmbc_pkg::CRC16_INIT};
        else
            crc_start = crc_cur;
    end

    assign r16 = crc_start[15:0];

    // byte update per mode
    always_comb
    begin
        if (is_crc32)
            crc_new = mmbc_pkg::crc32_term(crc_start[7:0] ^ item.data_byte)
                      ^ {8'h00, crc_start[31:8]};
        else if (crc_mode == mmbc_pkg::MODE_CCITT_AUG)
            crc_new = {16'h0000,
                       mmbc_pkg::ccitt_term(r16[15:8]) ^ {r16[7:0], item.data_byte}};
        else
            crc_new = {16'h0000,
                       {r16[7:0], 8'h00} ^ mmbc_pkg::ccitt_term(r16[15:8] ^ item.data_byte)};
    end

endmodule

`default_nettype wire

// File: rtl/mmbc_checker.sv
// port-level assertions for the multi-mode byte crc unit, bound to the top level
// depends on mmbc_pkg and multi_mode_byte_crc_unit_assert.svh
`default_nettype none

`include "multi_mode_byte_crc_unit_assert.svh"

module mmbc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        crc_mode_wr_en,
    input wire logic [1:0]  crc_mode_wr_data,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    logic [1:0] mode_shadow_reg;

    // copy of the mode register as written through the port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_shadow_reg <= mmbc_pkg::MODE_CCITT_AUG;
        else if (crc_mode_wr_en)
            mode_shadow_reg <= crc_mode_wr_data;
    end

    // a stalled result transaction holds its data
    `MMBC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // with no result pending the input side is always open
    `MMBC_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !m_tvalid, s_tready)

    // an accepted byte moves on from the input register to the output when the sink is ready
    `MMBC_ASSERT_NEXT(a_latency, clk, rst_n, (s_tvalid && s_tready) ##1 m_tready, m_tvalid)

    // 16-bit modes never set the upper half
    `MMBC_ASSERT_NOW(a_upper_zero, clk, rst_n, m_tvalid && !mode_shadow_reg[1], m_tdata[31:16] == 16'h0000)

endmodule

bind multi_mode_byte_crc_unit mmbc_checker u_mmbc_checker (.*);

`default_nettype wire

// File: dv/testbench.sv
// self-checking testbench for the multi-mode byte crc unit (ccitt-16 both forms, crc-32)
// depends on mmbc_pkg and multi_mode_byte_crc_unit; runs standalone
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // mode code 3 behaves as crc-32 since only bit 1 selects it
    localparam logic [1:0]  MODE_CRC32_ALIAS = 2'd3;
    localparam logic [15:0] CCITT_GEN        = 16'h1021;
    localparam logic [31:0] CRC32_GEN        = 32'hEDB8_8320;
    localparam logic [31:0] CRC32_START      = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC16_START      = 32'h0000_0000;
    localparam int          CYCLE_LIMIT      = 200000;
    localparam int          MAX_REPORTS      = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        crc_mode_wr_en = 1'b0;
    logic [1:0]  crc_mode_wr_data = 2'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    // predictor state and expected crc values in arrival order
    logic [1:0]  mode_shadow = mmbc_pkg::MODE_CCITT_AUG;
    logic [31:0] crc_state = CRC16_START;
    logic [31:0] crc_expected[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic recv_hold = 1'b0;
    int error_count = 0;
    int cycle_count = 0;

    multi_mode_byte_crc_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .crc_mode_wr_en   (crc_mode_wr_en),
        .crc_mode_wr_data (crc_mode_wr_data),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata)
    );

    // clock
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ccitt-16 term of one byte, bit-serial msb first from a zero register
    function automatic logic [15:0] ccitt_table_term(input logic [7:0] v);
        logic [15:0] acc;
        logic        fb;
        acc = 16'h0000;
        for (int i = 7; i >= 0; i--)
        begin
            fb  = acc[15] ^ v[i];
            acc = {acc[14:0], 1'b0} ^ (fb ? CCITT_GEN : 16'h0000);
        end
        return acc;
    endfunction

    // reflected crc-32 term of one byte, bit-serial lsb first from a zero register
    function automatic logic [31:0] crc32_table_term(input logic [7:0] v);
        logic [31:0] acc;
        logic        fb;
        acc = 32'h0;
        for (int i = 0; i < 8; i++)
        begin
            fb  = acc[0] ^ v[i];
            acc = {1'b0, acc[31:1]} ^ (fb ? CRC32_GEN : 32'h0);
        end
        return acc;
    endfunction

    // apply one accepted byte to the predicted crc register
    function automatic logic [31:0] advance_crc(input logic [7:0] b, input logic rs);
        logic [15:0] low;
        if (rs)
            crc_state = mode_shadow[1] ? CRC32_START : CRC16_START;
        low = crc_state[15:0];
        if (mode_shadow[1])
            crc_state = crc32_table_term(crc_state[7:0] ^ b) ^ {8'h00, crc_state[31:8]};
        else if (mode_shadow == mmbc_pkg::MODE_CCITT_AUG)
            crc_state = {16'h0000, ccitt_table_term(low[15:8]) ^ {low[7:0], b}};
        else
            crc_state = {16'h0000, {low[7:0], 8'h00} ^ ccitt_table_term(low[15:8] ^ b)};
        return crc_state;
    endfunction

    task automatic note_failure(input string what, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch: %s expected %08h actual %08h at cycle %0d",
                     what, exp_v, act_v, cycle_count);
    endtask

    // receiver: random stalls, plus a long hold when requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (recv_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker: each output transaction against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (crc_expected.size() == 0)
                note_failure("unexpected crc_value", 32'h0, m_tdata);
            else if (m_tdata !== crc_expected[0])
                note_failure("crc_value", crc_expected.pop_front(), m_tdata);
            else
                void'(crc_expected.pop_front());
        end
    end

    // offer one byte, hold it until taken, then record its expected crc
    task automatic send_byte(input logic [7:0] b, input logic rs);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= rs;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        crc_expected.push_back(advance_crc(b, rs));
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (crc_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // mode write, only with the pipeline empty
    task automatic write_crc_mode(input logic [1:0] m);
        wait_drained();
        crc_mode_wr_en   <= 1'b1;
        crc_mode_wr_data <= m;
        @(posedge clk);
        crc_mode_wr_en   <= 1'b0;
        mode_shadow = m;
    endtask

    // byte extremes, restart, every mode, mode switches that keep the register
    task automatic test_directed();
        // reset state: mode 0, register zero, no restart needed
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h31, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        // direct form continues from the augmented register
        write_crc_mode(mmbc_pkg::MODE_CCITT_DIRECT);
        send_byte(8'hA5, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        // crc-32 starts from a 16-bit register when not restarted
        write_crc_mode(mmbc_pkg::MODE_CRC32);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'hFF, 1'b0);
        // back to 16 bits without restart: only the low half is used
        write_crc_mode(mmbc_pkg::MODE_CCITT_DIRECT);
        send_byte(8'h3C, 1'b0);
        // alias of crc-32
        write_crc_mode(MODE_CRC32_ALIAS);
        send_byte(8'hC3, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        write_crc_mode(mmbc_pkg::MODE_CCITT_AUG);
        send_byte(8'h99, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    // random messages: restart on the first byte, random length, a little noise
    task automatic test_random_messages(input int count, input logic [1:0] m,
                                        input int idle_pct, input int stall_pct);
        int   bytes_left;
        logic rs;
        bytes_left = 0;
        write_crc_mode(m);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
        begin
            if (bytes_left == 0)
            begin
                rs = 1'b1;
                bytes_left = $urandom_range(1, 20);
            end
            else
                rs = ($urandom_range(31) == 0);
            bytes_left--;
            send_byte(8'($urandom_range(255)), rs);
        end
    endtask

    // receiver held off for a long stretch while the sender keeps offering bytes
    task automatic test_input_stall();
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                recv_hold <= 1'b1;
                repeat (60) @(posedge clk);
                recv_hold <= 1'b0;
            end
            begin
                for (int n = 0; n < 12; n++)
                    send_byte(8'($urandom_range(255)), n == 0);
            end
        join
    endtask

    // test sequence
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_messages(75, mmbc_pkg::MODE_CCITT_AUG, 0, 0);
        test_random_messages(75, mmbc_pkg::MODE_CRC32, 0, 0);
        test_random_messages(75, mmbc_pkg::MODE_CCITT_DIRECT, 64, 0);
        test_random_messages(75, MODE_CRC32_ALIAS, 64, 0);
        test_random_messages(75, mmbc_pkg::MODE_CRC32, 0, 64);
        test_random_messages(75, mmbc_pkg::MODE_CCITT_AUG, 0, 64);
        test_random_messages(75, mmbc_pkg::MODE_CCITT_DIRECT, 19, 19);
        test_random_messages(75, mmbc_pkg::MODE_CRC32, 19, 19);
        test_input_stall();

        wait_drained();
        repeat (10) @(posedge clk);
        if (crc_expected.size() != 0)
            note_failure("missing crc_value", crc_expected[0], 32'h0);

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/mmbc_pkg.sv
rtl/mmbc_crc_next.sv
rtl/multi_mode_byte_crc_unit.sv
rtl/mmbc_checker.sv
dv/testbench.sv
